@@ sv/ipv6nc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipv6nc_pkg
// Shared types and codes for the IPv6 neighbour cache update block.
// ----------------------------------------------------------------------------
package ipv6nc_pkg;

  localparam int unsigned KEY_W  = 128;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned CNT_W  = 6;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Item kinds.
  typedef enum logic {
    KIND_SOL = 1'b0,
    KIND_ADV = 1'b1
  } kind_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

  // One cache entry as held in the memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [MAC_W-1:0] mac;
    logic             reachable;
    logic             router;
  } entry_t;

endpackage

@@ sv/ipv6_neighbor_cache_update_top.sv @@
// ----------------------------------------------------------------------------
// ipv6_neighbor_cache_update_top
// Neighbour cache keyed by 128-bit IPv6 address, updated by solicitations
// and advertisements, with a linear search over one synchronous memory.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake           Ports
//  --------  ------------------  --------------------------------------------
//  item in   start & !busy       kind, addr_high, addr_low, has_link_addr,
//                                link_addr, flag_router, flag_solicited,
//                                flag_override
//  result    done (one cycle)    status, entry_index, entry_reachable,
//                                entry_router, entry_link_addr, entry_count
//
// The search reads one entry of the memory per cycle over its single read
// port, through a registered read. A hit ends the search early; on a miss
// it runs until every filled entry has been compared and it sees that no
// entry is left. The finishing state then does the write-back and registers
// the result strobe. A full table holds 32 entries by default. A new item
// can be taken in the strobe cycle, and not before the last one is done.
// Reset clears the fill count and the sequencer; the memory is not cleared,
// as only entries below the fill count are ever compared.
// The receiver cannot stall: each result is shown for exactly one cycle,
// and busy drops in that same cycle so that a new item may be taken.
//
module ipv6_neighbor_cache_update_top
  import ipv6nc_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [63:0]       addr_high,
  input  logic [63:0]       addr_low,
  input  logic              has_link_addr,
  input  logic [MAC_W-1:0]  link_addr,
  input  logic              flag_router,
  input  logic              flag_solicited,
  input  logic              flag_override,
  output logic              done,
  output logic [1:0]        status,
  output logic [IDX_W-1:0]  entry_index,
  output logic              entry_reachable,
  output logic              entry_router,
  output logic [MAC_W-1:0]  entry_link_addr,
  output logic [CNT_W-1:0]  entry_count
);

  // Index width for the memory, and a count width that can hold ENTRIES.
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // The cache itself: key, link address and flags for each entry.
  entry_t mem [ENTRIES];

  state_t state, state_next;

  // Latched item.
  kind_t            req_kind;
  logic [KEY_W-1:0] req_key;
  logic             req_has_mac;
  logic [MAC_W-1:0] req_mac;
  logic             req_router;
  logic             req_solicited;
  logic             req_override;

  // Search control.
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] rd_ptr;
  logic [IW-1:0] cmp_ptr;
  logic          cmp_valid;
  entry_t        rd_q;

  // Captured hit.
  logic          hit_r;
  logic [IW-1:0] hit_idx;
  entry_t        hit_entry;

  // Combinational control.
  logic          accept;
  logic          issue;
  logic          hit;
  logic          miss;
  logic          fin;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  entry_t        wr_entry;
  status_t       res_status;
  logic [IW-1:0] res_idx;
  entry_t        res_entry;
  logic          sol_ok;
  logic          table_full;

  assign accept = start && !busy;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit || miss) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs. The search issues one read per cycle while entries
  // remain and compares the registered data of the last read issued. It
  // stops on the first hit, or once every filled entry has been compared.
  always_comb begin
    busy  = (state != S_IDLE);
    issue = 1'b0;
    hit   = 1'b0;
    miss  = 1'b0;
    fin   = 1'b0;
    case (state)
      S_SEARCH: begin
        hit   = cmp_valid && (rd_q.key == req_key);
        issue = !hit && (rd_ptr < fill);
        miss  = !hit && !cmp_valid && !(rd_ptr < fill);
      end
      S_FINISH: begin
        fin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Update decision, made in the finishing cycle. The entry is written back
  // whole, using the payload captured at the hit.
  always_comb begin
    sol_ok     = req_has_mac && (req_key != '0);
    table_full = (fill == CW'(ENTRIES));
    wr_en      = 1'b0;
    wr_idx     = hit_idx;
    wr_entry   = hit_entry;
    res_status = ST_IGNORED;
    res_idx    = '0;
    res_entry  = '0;
    fill_next  = fill;
    if (req_kind == KIND_SOL && !sol_ok) begin
      res_status = ST_IGNORED;
    end else if (hit_r) begin
      if (req_kind == KIND_SOL) begin
        wr_entry.mac       = req_mac;
        wr_entry.reachable = 1'b1;
      end else begin
        if (req_override || req_solicited) begin
          if (req_has_mac) begin
            wr_entry.mac = req_mac;
          end
          wr_entry.reachable = 1'b1;
        end
        wr_entry.router = req_router;
      end
      wr_en      = fin;
      res_status = ST_UPDATED;
      res_idx    = hit_idx;
      res_entry  = wr_entry;
    end else if (req_kind == KIND_SOL || req_has_mac) begin
      if (table_full) begin
        res_status = ST_FULL;
      end else begin
        wr_idx             = fill[IW-1:0];
        wr_entry.key       = req_key;
        wr_entry.mac       = req_mac;
        wr_entry.reachable = 1'b1;
        wr_entry.router    = (req_kind == KIND_ADV) ? req_router : 1'b0;
        wr_en              = fin;
        fill_next          = fill + CW'(1);
        res_status         = ST_INSERTED;
        res_idx            = fill[IW-1:0];
        res_entry          = wr_entry;
      end
    end
  end

  // Memory: one read port, registered, and one write port. The read port
  // runs every cycle, but its data is compared only in the search; writes
  // happen only in the finishing cycle, so no compared read meets a write.
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rd_ptr    <= '0;
      cmp_valid <= 1'b0;
      hit_r     <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      done      <= fin;
      cmp_valid <= issue;
      if (accept) begin
        rd_ptr <= '0;
        hit_r  <= 1'b0;
      end else if (issue) begin
        rd_ptr <= rd_ptr + CW'(1);
      end
      if (hit) begin
        hit_r <= 1'b1;
      end
      if (fin) begin
        fill <= fill_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind      <= kind_t'(kind);
      req_key       <= {addr_high, addr_low};
      req_has_mac   <= has_link_addr;
      req_mac       <= link_addr;
      req_router    <= flag_router;
      req_solicited <= flag_solicited;
      req_override  <= flag_override;
    end
    if (issue) begin
      cmp_ptr <= rd_ptr[IW-1:0];
    end
    if (hit) begin
      hit_idx   <= cmp_ptr;
      hit_entry <= rd_q;
    end
    if (fin) begin
      status          <= res_status;
      entry_index     <= IDX_W'(res_idx);
      entry_reachable <= res_entry.reachable;
      entry_router    <= res_entry.router;
      entry_link_addr <= res_entry.mac;
      entry_count     <= CNT_W'(fill_next);
    end
  end

endmodule

@@ sv/ipv6nc_check.sv @@
// ----------------------------------------------------------------------------
// ipv6nc_check
// Port-level checks on the neighbour cache update block, bound to its top.
// ----------------------------------------------------------------------------
module ipv6nc_check
  import ipv6nc_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [1:0]       status,
  input logic [IDX_W-1:0] entry_index,
  input logic             entry_reachable,
  input logic             entry_router,
  input logic [MAC_W-1:0] entry_link_addr,
  input logic [CNT_W-1:0] entry_count
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result is shown only once the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Entries are always reachable once touched.
  a_touched_reachable: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_UPDATED || status == ST_INSERTED)) |-> entry_reachable)
    else $error("touched entry not reachable");

  // Ignored or dropped items report an empty entry.
  a_untouched_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_IGNORED || status == ST_FULL)) |->
      (entry_index == '0 && !entry_reachable && !entry_router &&
       entry_link_addr == '0))
    else $error("untouched result carries entry data");

  // A full-table drop only happens with the table at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entry_count == CNT_W'(ENTRIES)))
    else $error("table full reported below capacity");

endmodule

bind ipv6_neighbor_cache_update_top ipv6nc_check #(.ENTRIES(ENTRIES)) u_ipv6nc_check (.*);

@@ tb/sv/ipv6_neighbor_cache_checker.sv @@
// ----------------------------------------------------------------------------
// ipv6_neighbor_cache_checker
// Watches the item and result channels of the neighbour cache, keeps its own
// copy of the cache to work out each expected result, and compares the
// results in order.
// ----------------------------------------------------------------------------
module ipv6_neighbor_cache_checker
  import ipv6nc_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              kind,
  input  logic [63:0]       addr_high,
  input  logic [63:0]       addr_low,
  input  logic              has_link_addr,
  input  logic [MAC_W-1:0]  link_addr,
  input  logic              flag_router,
  input  logic              flag_solicited,
  input  logic              flag_override,
  input  logic              done,
  input  logic [1:0]        status,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic              entry_reachable,
  input  logic              entry_router,
  input  logic [MAC_W-1:0]  entry_link_addr,
  input  logic [CNT_W-1:0]  entry_count,
  output int                mismatch_count,
  output int                open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] index;
    logic             reachable;
    logic             router;
    logic [MAC_W-1:0] mac;
    logic [CNT_W-1:0] count;
  } cache_result_t;

  logic [63:0]      nb_key_high [ENTRIES];
  logic [63:0]      nb_key_low  [ENTRIES];
  logic [MAC_W-1:0] nb_mac      [ENTRIES];
  logic             nb_reachable[ENTRIES];
  logic             nb_router   [ENTRIES];
  int unsigned      nb_fill;

  cache_result_t    expected_results[$];
  int               mismatches;

  initial begin
    mismatch_count = 0;
    open_count     = 0;
    mismatches     = 0;
    nb_fill        = 0;
  end

  // Applies one message to the cache copy and returns the result it causes.
  function automatic cache_result_t apply_neighbor_msg(
    kind_t k, logic [63:0] hi, logic [63:0] lo, logic has_mac,
    logic [MAC_W-1:0] mac, logic fr, logic fs, logic fo);
    cache_result_t r;
    int            hit;
    int            slot;
    int            i;
    logic          add_entry;
    logic          add_router;
    r          = '{ST_IGNORED, '0, 1'b0, 1'b0, '0, '0};
    hit        = -1;
    slot       = -1;
    add_entry  = 1'b0;
    add_router = 1'b0;
    for (i = 0; i < int'(nb_fill); i++) begin
      if (hit < 0 && nb_key_high[i] == hi && nb_key_low[i] == lo) hit = i;
    end
    if (k == KIND_SOL) begin
      if (has_mac && (hi != '0 || lo != '0)) begin
        if (hit >= 0) begin
          nb_mac[hit]       = mac;
          nb_reachable[hit] = 1'b1;
          r.status          = ST_UPDATED;
          slot              = hit;
        end else begin
          add_entry = 1'b1;
        end
      end
    end else begin
      if (hit >= 0) begin
        if (fo || fs) begin
          if (has_mac) nb_mac[hit] = mac;
          nb_reachable[hit] = 1'b1;
        end
        nb_router[hit] = fr;
        r.status       = ST_UPDATED;
        slot           = hit;
      end else if (has_mac) begin
        add_entry  = 1'b1;
        add_router = fr;
      end
    end
    if (add_entry) begin
      if (nb_fill < ENTRIES) begin
        slot               = nb_fill;
        nb_key_high[slot]  = hi;
        nb_key_low[slot]   = lo;
        nb_mac[slot]       = mac;
        nb_reachable[slot] = 1'b1;
        nb_router[slot]    = add_router;
        nb_fill            = nb_fill + 1;
        r.status           = ST_INSERTED;
      end else begin
        r.status = ST_FULL;
      end
    end
    if (slot >= 0) begin
      r.index     = IDX_W'(slot);
      r.reachable = nb_reachable[slot];
      r.router    = nb_router[slot];
      r.mac       = nb_mac[slot];
    end
    r.count = CNT_W'(nb_fill);
    return r;
  endfunction

  // A result and a new item can meet at one edge: the result belongs to the
  // earlier item, so it is checked before the new item is applied.
  always @(posedge clk) begin
    cache_result_t want;
    if (rst) begin
      nb_fill = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no item outstanding (status %0d index %0d)",
                     $realtime, status, entry_index);
        end else begin
          want = expected_results.pop_front();
          if (status != want.status || entry_index != want.index ||
              entry_reachable != want.reachable || entry_router != want.router ||
              entry_link_addr != want.mac || entry_count != want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch, expected status %0d index %0d reach %0b ",
                        "router %0b mac %h count %0d, got status %0d index %0d ",
                        "reach %0b router %0b mac %h count %0d"},
                       $realtime, want.status, want.index, want.reachable,
                       want.router, want.mac, want.count, status, entry_index,
                       entry_reachable, entry_router, entry_link_addr, entry_count);
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_neighbor_msg(kind_t'(kind), addr_high,
          addr_low, has_link_addr, link_addr, flag_router, flag_solicited,
          flag_override));
    end
    mismatch_count <= mismatches;
    open_count     <= expected_results.size();
  end

endmodule

@@ tb/sv/tb_ipv6_neighbor_cache_update_top.sv @@
// ----------------------------------------------------------------------------
// tb_ipv6_neighbor_cache_update_top
// Drives solicitations and advertisements into the neighbour cache, first a
// short directed run over the special cases and then random traffic that
// mostly revisits known addresses, while a checker predicts every result.
// ----------------------------------------------------------------------------
module tb_ipv6_neighbor_cache_update_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ipv6nc_pkg::*;

  localparam int unsigned ENTRIES = 32;
  // Number of random items, and how many of the last ones go without gaps.
  localparam int RANDOM_ITEMS  = 400;
  localparam int CALM_TAIL     = 60;
  // Quiet cycles at the end, enough for any straggling result to show up.
  localparam int SETTLE_CYCLES = 40;
  // The longest quiet stretch in a correct run is a sender gap plus one full
  // search; the watchdog allows far more than that.
  localparam int STALL_LIMIT   = 2000;

  logic             clk;
  logic             rst            = 1'b1;
  logic             start          = 1'b0;
  logic             busy;
  logic             kind           = KIND_SOL;
  logic [63:0]      addr_high      = '0;
  logic [63:0]      addr_low       = '0;
  logic             has_link_addr  = 1'b0;
  logic [MAC_W-1:0] link_addr      = '0;
  logic             flag_router    = 1'b0;
  logic             flag_solicited = 1'b0;
  logic             flag_override  = 1'b0;
  logic             done;
  logic [1:0]       status;
  logic [IDX_W-1:0] entry_index;
  logic             entry_reachable;
  logic             entry_router;
  logic [MAC_W-1:0] entry_link_addr;
  logic [CNT_W-1:0] entry_count;
  int               mismatch_count;
  int               open_count;

  // Every address that has been sent, so that random traffic can come back
  // to addresses that are likely to sit in the cache and hit them.
  logic [63:0]      seen_high[$];
  logic [63:0]      seen_low[$];

  ipv6_neighbor_cache_update_top #(.ENTRIES(ENTRIES)) u_top (.*);

  ipv6_neighbor_cache_checker #(.ENTRIES(ENTRIES)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Presents one item and holds it until the block takes it. Start is left
  // high, so a following item goes out back to back unless a gap is made.
  task automatic send_item(input logic k, input logic [63:0] hi,
                           input logic [63:0] lo, input logic has_mac,
                           input logic [MAC_W-1:0] mac, input logic fr,
                           input logic fs, input logic fo);
    kind           <= k;
    addr_high      <= hi;
    addr_low       <= lo;
    has_link_addr  <= has_mac;
    link_addr      <= mac;
    flag_router    <= fr;
    flag_solicited <= fs;
    flag_override  <= fo;
    start          <= 1'b1;
    seen_high.push_back(hi);
    seen_low.push_back(lo);
    do @(posedge clk); while (busy);
  endtask

  // The watchdog restarts whenever an item or a result crosses a channel.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int               n;
    int               pick;
    int               slot;
    logic [63:0]      hi;
    logic [63:0]      lo;
    logic [MAC_W-1:0] mac;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The all-ones address goes in first by solicitation.
    send_item(KIND_SOL, '1, '1, 1'b1, '1, 1'b0, 1'b0, 1'b0);
    // A solicitation from the unspecified address is ignored.
    send_item(KIND_SOL, '0, '0, 1'b1, 48'h0000_1111_2222, 1'b1, 1'b1, 1'b1);
    // A solicitation without a link address is ignored, flags set or not.
    send_item(KIND_SOL, 64'h2001_0db8_0000_0001, 64'h1, 1'b0, '1, 1'b1, 1'b1, 1'b1);
    // An advertisement that misses without a link address is ignored.
    send_item(KIND_ADV, 64'hfe80_0000_0000_0000, 64'h2, 1'b0, '1, 1'b1, 1'b1, 1'b1);
    // An advertisement for the all-zero target is an ordinary key and is
    // inserted with its router flag.
    send_item(KIND_ADV, '0, '0, 1'b1, '0, 1'b1, 1'b0, 1'b0);
    // A hit without override or solicited only touches the router flag.
    send_item(KIND_ADV, '1, '1, 1'b1, '0, 1'b1, 1'b0, 1'b0);
    // Solicited: the link address is copied and the entry made reachable.
    send_item(KIND_ADV, '1, '1, 1'b1, 48'h0123_4567_89ab, 1'b1, 1'b1, 1'b0);
    // Override without a link address keeps the stored one, router drops.
    send_item(KIND_ADV, '1, '1, 1'b0, '1, 1'b0, 1'b0, 1'b1);
    // A solicitation hit replaces the link address and keeps the router flag.
    send_item(KIND_SOL, '1, '1, 1'b1, '0, 1'b0, 1'b1, 1'b1);
    // Keys with a single bit set in one half only.
    send_item(KIND_ADV, 64'h8000_0000_0000_0000, '0, 1'b1, 48'h8000_0000_0001,
              1'b0, 1'b1, 1'b1);
    send_item(KIND_SOL, '0, 64'h1, 1'b1, 48'hfedc_ba98_7654, 1'b1, 1'b0, 1'b1);
    // Hit on the all-zero target with both flags and a fresh link address.
    send_item(KIND_ADV, '0, '0, 1'b1, '1, 1'b0, 1'b1, 1'b1);
    // The all-zero target again, hit without the flags: router set again.
    send_item(KIND_ADV, '0, '0, 1'b0, '0, 1'b1, 1'b0, 1'b0);
    // A solicitation hit on a key first made by an advertisement.
    send_item(KIND_SOL, 64'h8000_0000_0000_0000, '0, 1'b1, 48'h5555_aaaa_5555,
              1'b0, 1'b0, 1'b0);

    // Random part. Most items come back to a known address, a few use the
    // all-zero and all-ones keys, and the rest bring new addresses which
    // fill the table and, once it is full, get dropped.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        slot = $urandom_range(seen_high.size() - 1);
        hi   = seen_high[slot];
        lo   = seen_low[slot];
      end else if (pick < 60) begin
        hi = '0;
        lo = '0;
      end else if (pick < 63) begin
        hi = '1;
        lo = '1;
      end else begin
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
      end
      mac = MAC_W'({$urandom, $urandom});
      send_item(1'($urandom_range(1)), hi, lo, $urandom_range(9) < 8, mac,
                1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
      // Gaps now and then, none in the closing stretch.
      // The gap starts once the block is free again, so that start is seen
      // low while the block could take an item.
      if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(9) < 3) begin
        start <= 1'b0;
        do @(posedge clk); while (busy);
        repeat ($urandom_range(4, 1) - 1) @(posedge clk);
      end
    end
    start <= 1'b0;

    // Let the checker take in the last item before watching its count.
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
